// ===== design/rrts_pkg.sv =====
`default_nettype none
package rrts_pkg;
  localparam int MaxTasks = 16;
  localparam int SlotW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_WAITING = 3'd3;
  localparam logic [2:0] ST_TERM = 3'd4;

  localparam logic [1:0] TY_BOOT = 2'd2;
  localparam logic [1:0] TY_IDLE = 2'd3;

  localparam logic [2:0] K_TICK = 3'd0;
  localparam logic [2:0] K_ADMIT = 3'd1;
  localparam logic [2:0] K_SLEEP = 3'd2;
  localparam logic [2:0] K_EXIT = 3'd3;
  localparam logic [2:0] K_YIELD = 3'd4;
  localparam logic [2:0] K_RECLAIM = 3'd5;

  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_REFUSED = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;

  localparam logic [1:0] CFG_TIMESLICE = 2'd0;
  localparam logic [1:0] CFG_IDLE = 2'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  task_slot;
    logic [1:0]  task_type;
    logic [31:0] nap_ticks;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        running_valid;
    logic        switched;
    logic [1:0]  status;
    logic [15:0] woken_mask;
    logic [15:0] reclaimed_mask;
  } out_item_t;
endpackage
`default_nettype wire

// ===== design/rrts_if.sv =====
`default_nettype none
interface rrts_in_if import rrts_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrts_out_if import rrts_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
// Admit, refused and invalid events go from idle straight to result build and
// output; tick and reclaim first walk the table (one slot per cycle walk), and a
// tick that forces a yield then also scans for the next task; yield, sleep and
// exit scan for the next task. One transaction at a time: ready only while idle,
// so the next input is taken at the earliest in the cycle after the result leaves.
// Reset (synchronous rst_n low): all slots empty, no task running, slice 10, idle 0.
`default_nettype none
module round_robin_task_scheduler import rrts_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [7:0]  cfg_data
);
  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;  // tick / reclaim table walk
  localparam logic [2:0] S_SCAN = 3'd2;  // next-task scan (yield, sleep, exit, expired tick)
  localparam logic [2:0] S_DONE = 3'd3;  // build result
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  slot_state_r [MaxTasks];
  logic [1:0]  slot_type_r [MaxTasks];
  logic [31:0] sleep_r [MaxTasks];
  logic [SlotW-1:0] cur_r;
  logic        cur_v_r;
  logic [7:0]  slice_r;
  logic [7:0]  tslice_r;
  logic [3:0]  idle_r;
  in_item_t    item_r;
  logic [CntW-1:0] cnt_r;
  logic        found_r;
  logic [SlotW-1:0] next_r;
  logic        sw_r;
  logic [1:0]  sts_r;
  logic [15:0] woken_r, recl_r;
  out_item_t   res_r;

  // one slot examined per cycle
  logic [SlotW-1:0] idx;
  logic [SlotW-1:0] scan_idx;
  assign idx = cnt_r[SlotW-1:0];
  assign scan_idx = cur_v_r ? SlotW'(cur_r + SlotW'(cnt_r)) : idx;

  function automatic logic runnable(input logic [2:0] s);
    return (s == ST_READY) || (s == ST_RUNNING);
  endfunction

  logic cur_running;
  assign cur_running = cur_v_r && (slot_state_r[cur_r] == ST_RUNNING);

  logic idle_ok;
  assign idle_ok = (32'(idle_r) < MaxTasks) &&
                   runnable(slot_state_r[SlotW'(idle_r)]);

  logic [15:0] bit16;
  assign bit16 = (32'(idx) < 16) ? (16'd1 << idx[3:0]) : 16'd0;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = res_r;

  // scan covers slots cur+1..cur+15 with a current task, else 0..15
  logic [CntW-1:0] scan_end;
  assign scan_end = CntW'(MaxTasks - 1);

  // sleep, exit and yield with a current task start the scan one slot past it
  logic scan_from_next;
  assign scan_from_next = cur_v_r && (in_ch.data.kind == K_SLEEP ||
                          in_ch.data.kind == K_EXIT || in_ch.data.kind == K_YIELD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r <= '0;
      cur_v_r <= 1'b0;
      slice_r <= '0;
      tslice_r <= 8'd10;
      idle_r <= '0;
      for (int i = 0; i < MaxTasks; i++) begin
        slot_state_r[i] <= ST_EMPTY;
        slot_type_r[i] <= '0;
        sleep_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_TIMESLICE) tslice_r <= cfg_data;
        else if (cfg_index == CFG_IDLE) idle_r <= cfg_data[3:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r <= in_ch.data;
            sw_r <= 1'b0;
            woken_r <= '0;
            recl_r <= '0;
            found_r <= 1'b0;
            cnt_r <= scan_from_next ? CntW'(1) : '0;
            unique case (in_ch.data.kind)
              K_TICK, K_RECLAIM, K_YIELD: sts_r <= STS_OK;
              K_ADMIT: begin
                if (32'(in_ch.data.task_slot) >= MaxTasks) sts_r <= STS_INVALID;
                else if (slot_state_r[SlotW'(in_ch.data.task_slot)] != ST_EMPTY)
                  sts_r <= STS_REFUSED;
                else begin
                  sts_r <= STS_OK;
                  slot_state_r[SlotW'(in_ch.data.task_slot)] <= ST_READY;
                  slot_type_r[SlotW'(in_ch.data.task_slot)] <= in_ch.data.task_type;
                  sleep_r[SlotW'(in_ch.data.task_slot)] <= '0;
                end
              end
              K_SLEEP: begin
                if (!cur_running) sts_r <= STS_INVALID;
                else begin
                  sts_r <= STS_OK;
                  slot_state_r[cur_r] <= ST_WAITING;
                  sleep_r[cur_r] <= in_ch.data.nap_ticks;
                end
              end
              K_EXIT: begin
                if (!cur_running) sts_r <= STS_INVALID;
                else if (slot_type_r[cur_r] == TY_BOOT || slot_type_r[cur_r] == TY_IDLE)
                  sts_r <= STS_REFUSED;
                else begin
                  sts_r <= STS_OK;
                  slot_state_r[cur_r] <= ST_TERM;
                end
              end
              default: sts_r <= STS_INVALID;
            endcase
          end
        end
        S_WALK: begin
          if (cnt_r < CntW'(MaxTasks)) begin
            if (item_r.kind == K_TICK) begin
              if (slot_state_r[idx] == ST_WAITING) begin
                if (sleep_r[idx] <= 32'd1) begin
                  sleep_r[idx] <= '0;
                  slot_state_r[idx] <= ST_READY;
                  woken_r <= woken_r | bit16;
                end else sleep_r[idx] <= sleep_r[idx] - 32'd1;
              end
            end else if (slot_state_r[idx] == ST_TERM &&
                         slot_type_r[idx] != TY_BOOT && slot_type_r[idx] != TY_IDLE) begin
              slot_state_r[idx] <= ST_EMPTY;
              slot_type_r[idx] <= '0;
              sleep_r[idx] <= '0;
              recl_r <= recl_r | bit16;
              if (cur_v_r && cur_r == idx) begin
                cur_v_r <= 1'b0;
                cur_r <= '0;
                slice_r <= '0;
              end
            end
            cnt_r <= cnt_r + CntW'(1);
          end else if (item_r.kind == K_TICK && cur_running) begin
            // slice accounting after the timers
            if (slice_r <= 8'd1) begin
              slice_r <= '0;
              cnt_r <= cur_v_r ? CntW'(1) : '0;
            end else slice_r <= slice_r - 8'd1;
          end
        end
        S_SCAN: begin
          if (cnt_r <= scan_end && !found_r) begin
            if (runnable(slot_state_r[scan_idx])) begin
              found_r <= 1'b1;
              next_r <= scan_idx;
            end
            cnt_r <= cnt_r + CntW'(1);
          end else begin
            // commit the pick
            if (found_r || idle_ok || cur_v_r) begin
              logic [SlotW-1:0] nx;
              nx = found_r ? next_r : (idle_ok ? SlotW'(idle_r) : cur_r);
              slice_r <= (32'(nx) == 32'(idle_r)) ? 8'd1 : tslice_r;
              if (!(cur_v_r && nx == cur_r)) begin
                if (cur_v_r && slot_state_r[cur_r] == ST_RUNNING)
                  slot_state_r[cur_r] <= ST_READY;
                slot_state_r[nx] <= ST_RUNNING;
                cur_r <= nx;
                cur_v_r <= 1'b1;
                sw_r <= 1'b1;
              end
            end
          end
        end
        S_DONE: begin
          res_r.running_valid <= cur_running;
          res_r.running_task <= cur_running ? 4'(cur_r) : 4'd0;
          res_r.switched <= sw_r;
          res_r.status <= sts_r;
          res_r.woken_mask <= woken_r;
          res_r.reclaimed_mask <= recl_r;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  logic scan_start_ok;
  assign scan_start_ok = (item_r.kind == K_TICK) ? (cur_running && slice_r <= 8'd1)
                         : 1'b0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.data.kind)
            K_TICK, K_RECLAIM: state_nxt = S_WALK;
            K_YIELD: state_nxt = S_SCAN;
            K_SLEEP: state_nxt = cur_running ? S_SCAN : S_DONE;
            K_EXIT: state_nxt = (cur_running && slot_type_r[cur_r] != TY_BOOT &&
                                 slot_type_r[cur_r] != TY_IDLE) ? S_SCAN : S_DONE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (cnt_r >= CntW'(MaxTasks))
          state_nxt = scan_start_ok ? S_SCAN : S_DONE;
      end
      S_SCAN: if (!(cnt_r <= scan_end && !found_r)) state_nxt = S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.running_valid |-> cur_v_r)
    else $error("running without current task");
  a_sw_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.switched |-> out_ch.data.status == STS_OK)
    else $error("switch on refused event");
  a_masks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.woken_mask == 16'd0 ||
                      out_ch.data.reclaimed_mask == 16'd0))
    else $error("both masks set");
endmodule
`default_nettype wire

// ===== tb/sv/rrts_scoreboard.sv =====
package rrts_sb_pkg;
  import rrts_pkg::*;

  class rrts_scoreboard;
    logic [2:0]  slot_st [MaxTasks];
    logic [1:0]  slot_ty [MaxTasks];
    logic [31:0] nap_left [MaxTasks];
    logic [3:0]  cur_slot;
    bit          cur_valid;
    logic [7:0]  slice_left;
    logic [7:0]  timeslice;
    logic [3:0]  idle_slot;
    out_item_t   pending_q[$];
    int          errors;
    int          checked;

    function new();
      errors = 0;
      checked = 0;
      timeslice = 8'd10;
      idle_slot = 4'd0;
      cur_slot = '0;
      cur_valid = 0;
      slice_left = '0;
      foreach (slot_st[i]) begin
        slot_st[i] = ST_EMPTY;
        slot_ty[i] = '0;
        nap_left[i] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      if (idx == CFG_TIMESLICE) timeslice = val;
      else if (idx == CFG_IDLE) idle_slot = val[3:0];
    endfunction

    function bit runnable(int s);
      return slot_st[s] == ST_READY || slot_st[s] == ST_RUNNING;
    endfunction

    function bit special(int s);
      return slot_ty[s] == TY_BOOT || slot_ty[s] == TY_IDLE;
    endfunction

    // round-robin pick; returns 1 when the current task changes
    function bit pick_next();
      bit found;
      int nxt;
      int s;
      found = 0;
      nxt = 0;
      for (int k = 0; k < MaxTasks && !found; k++) begin
        if (cur_valid) begin
          if (k == 0) continue;
          s = (cur_slot + k) % MaxTasks;
        end else begin
          s = k;
        end
        if (runnable(s)) begin
          found = 1;
          nxt = s;
        end
      end
      if (!found && idle_slot < MaxTasks && runnable(idle_slot)) begin
        found = 1;
        nxt = idle_slot;
      end
      if (!found) begin
        if (!cur_valid) return 0;
        nxt = cur_slot;
      end
      slice_left = (nxt == idle_slot) ? 8'd1 : timeslice;
      if (cur_valid && nxt == cur_slot) return 0;
      if (cur_valid && slot_st[cur_slot] == ST_RUNNING) slot_st[cur_slot] = ST_READY;
      slot_st[nxt] = ST_RUNNING;
      cur_slot = 4'(nxt);
      cur_valid = 1;
      return 1;
    endfunction

    function bit cur_running();
      return cur_valid && slot_st[cur_slot] == ST_RUNNING;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t r;
      r = '0;
      case (ev.kind)
        K_TICK: begin
          for (int s = 0; s < MaxTasks; s++) begin
            if (slot_st[s] != ST_WAITING) continue;
            if (nap_left[s] > 0) nap_left[s]--;
            if (nap_left[s] == 0) begin
              slot_st[s] = ST_READY;
              r.woken_mask[s] = 1'b1;
            end
          end
          if (cur_running()) begin
            if (slice_left > 0) slice_left--;
            if (slice_left == 0) r.switched = pick_next();
          end
        end
        K_ADMIT: begin
          if (slot_st[ev.task_slot] != ST_EMPTY) r.status = STS_REFUSED;
          else begin
            slot_st[ev.task_slot] = ST_READY;
            slot_ty[ev.task_slot] = ev.task_type;
            nap_left[ev.task_slot] = '0;
          end
        end
        K_SLEEP: begin
          if (!cur_running()) r.status = STS_INVALID;
          else begin
            slot_st[cur_slot] = ST_WAITING;
            nap_left[cur_slot] = ev.nap_ticks;
            r.switched = pick_next();
          end
        end
        K_EXIT: begin
          if (!cur_running()) r.status = STS_INVALID;
          else if (special(cur_slot)) r.status = STS_REFUSED;
          else begin
            slot_st[cur_slot] = ST_TERM;
            r.switched = pick_next();
          end
        end
        K_YIELD: r.switched = pick_next();
        K_RECLAIM: begin
          for (int s = 0; s < MaxTasks; s++) begin
            if (slot_st[s] != ST_TERM || special(s)) continue;
            slot_st[s] = ST_EMPTY;
            slot_ty[s] = '0;
            nap_left[s] = '0;
            r.reclaimed_mask[s] = 1'b1;
            if (cur_valid && cur_slot == s) begin
              cur_valid = 0;
              cur_slot = '0;
              slice_left = '0;
            end
          end
        end
        default: r.status = STS_INVALID;
      endcase
      r.running_valid = cur_running();
      r.running_task = r.running_valid ? cur_slot : 4'd0;
      pending_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      checked++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.running_task !== exp.running_task) begin
        $error("running_task exp %0d got %0d", exp.running_task, got.running_task);
        errors++;
      end
      if (got.running_valid !== exp.running_valid) begin
        $error("running_valid exp %0d got %0d", exp.running_valid, got.running_valid);
        errors++;
      end
      if (got.switched !== exp.switched) begin
        $error("switched exp %0d got %0d", exp.switched, got.switched);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.woken_mask !== exp.woken_mask) begin
        $error("woken_mask exp %h got %h", exp.woken_mask, got.woken_mask);
        errors++;
      end
      if (got.reclaimed_mask !== exp.reclaimed_mask) begin
        $error("reclaimed_mask exp %h got %h", exp.reclaimed_mask, got.reclaimed_mask);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== tb/sv/round_robin_task_scheduler_test.sv =====
module round_robin_task_scheduler_test;
  import rrts_pkg::*;
  import rrts_sb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // kinds the block must flag as invalid
  localparam logic [2:0] K_BAD6 = 3'd6;
  localparam logic [2:0] K_BAD7 = 3'd7;
  localparam int NumItems = 700;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       rx_hold;
  int         sent;

  rrts_in_if  in_ch ();
  rrts_out_if out_ch ();
  rrts_scoreboard sb;

  round_robin_task_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_item_t make_item();
    in_item_t it;
    int p;
    int q;
    p = $urandom_range(0, 99);
    q = $urandom_range(0, 9);
    if (p < 30) it.kind = K_TICK;
    else if (p < 50) it.kind = K_ADMIT;
    else if (p < 60) it.kind = K_SLEEP;
    else if (p < 68) it.kind = K_EXIT;
    else if (p < 83) it.kind = K_YIELD;
    else if (p < 95) it.kind = K_RECLAIM;
    else if (p < 97) it.kind = K_BAD6;
    else it.kind = K_BAD7;
    it.task_slot = 4'($urandom_range(0, 15));
    it.task_type = 2'($urandom_range(0, 3));
    if (q < 6) it.nap_ticks = 32'($urandom_range(0, 4));
    else if (q < 8) it.nap_ticks = 32'($urandom_range(5, 40));
    else if (q == 8) it.nap_ticks = 32'hFFFF_FFFF;
    else it.nap_ticks = $urandom;
    return it;
  endfunction

  // holds valid until the transaction is taken; caller drops valid
  task automatic drive_item(input in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(it);
    sent++;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // caller drops cfg_we after the last write
  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic reconfigure();
    logic [7:0] ts;
    int pick;
    pick = $urandom_range(0, 4);
    if (pick < 4) ts = 8'(pick);
    else ts = 8'($urandom_range(4, 255));
    drain();
    write_cfg(CFG_TIMESLICE, ts);
    write_cfg(CFG_IDLE, 8'($urandom_range(0, 15)));
    cfg_we <= 1'b0;
  endtask

  // main sender
  initial begin
    int gap;
    sb = new();
    sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int n = 0; n < NumItems; n++) begin
      if (n == 100 || n == 350 || n == 550) begin
        in_ch.valid <= 1'b0;
        reconfigure();
      end
      drive_item(make_item());
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    drain();
    repeat (5) @(posedge clk);
    $display("Ran %0d events: ticks, admits, sleeps, exits, yields, reclaims, bad kinds,",
             sent);
    $display("with random gaps, a long output stall and idle-time register updates.");
    if (sb.errors == 0 && sb.pending_q.size() == 0 && sb.checked == sent)
      $display("round_robin_task_scheduler verification clean");
    else
      $display("round_robin_task_scheduler verification failed");
    $finish;
  end

  // receiver
  initial begin
    int w;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      w = $urandom_range(0, 12);
      if (w != 0 || rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.data);
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    rx_hold = 1'b0;
    wait (rst_n === 1'b1);
    repeat (3000) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #1000000;
    $display("round_robin_task_scheduler verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
design/rrts_pkg.sv
design/rrts_if.sv
design/round_robin_task_scheduler.sv
tb/sv/rrts_scoreboard.sv
tb/sv/round_robin_task_scheduler_test.sv
